// ----- hw/rtl/odr_pkg.sv -----
// ----------------------------------------------------------------------------
// odr_pkg: shared definitions for the odometry dead reckoning unit
// Widths, CORDIC constants, arctangent table and register indexes.
// ----------------------------------------------------------------------------
package odr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int CORDIC_IW    = $clog2(CORDIC_ITERS);

    // CORDIC datapath width (x, y, z)
    localparam int CW = 33;
    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN    = 33'sd2147483648;

    // serial multiplier operand widths
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_BW);

    // configuration register indexes
    localparam logic [7:0] CFG_PULSE_MAX      = 8'd0;
    localparam logic [7:0] CFG_WRAP_THRESHOLD = 8'd1;
    localparam logic [7:0] CFG_REVERSE_WINDOW = 8'd2;
    localparam logic [7:0] CFG_DIST_PER_PULSE = 8'd3;

    localparam logic [15:0] HEADING_INIT = 16'd16384;

    // arctangent of 2^-idx as a 32-bit binary angle
    function automatic logic signed [CW-1:0] atan_val(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        unique case (idx)
            5'd0:  v = 33'sh020000000;
            5'd1:  v = 33'sh012E4051E;
            5'd2:  v = 33'sh009FB385B;
            5'd3:  v = 33'sh0051111D4;
            5'd4:  v = 33'sh0028B0D43;
            5'd5:  v = 33'sh00145D7E1;
            5'd6:  v = 33'sh000A2F61E;
            5'd7:  v = 33'sh000517C55;
            5'd8:  v = 33'sh00028BE53;
            5'd9:  v = 33'sh000145F2F;
            5'd10: v = 33'sh0000A2F98;
            5'd11: v = 33'sh0000517CC;
            5'd12: v = 33'sh000028BE6;
            5'd13: v = 33'sh0000145F3;
            5'd14: v = 33'sh00000A2FA;
            5'd15: v = 33'sh00000517D;
            5'd16: v = 33'sh0000028BE;
            5'd17: v = 33'sh00000145F;
            5'd18: v = 33'sh000000A30;
            5'd19: v = 33'sh000000518;
            5'd20: v = 33'sh00000028C;
            5'd21: v = 33'sh000000146;
            5'd22: v = 33'sh0000000A3;
            5'd23: v = 33'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // binary angle read as a value in (-32768, 32768]
    function automatic logic signed [16:0] angle_val(input logic [15:0] a);
        logic signed [16:0] v;
        if (a == 16'h8000) begin
            v = 17'sd32768;
        end else begin
            v = {a[15], a};
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/odr_serial_mult.sv -----
// ----------------------------------------------------------------------------
// odr_serial_mult: bit-serial signed multiplier
// Consumes one multiplier bit per cycle; the final bit carries negative weight.
// ----------------------------------------------------------------------------
module odr_serial_mult import odr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic                     o_busy,
    output logic signed [MUL_PW-1:0] o_prod
);

    logic signed [MUL_AW-1:0] r_a;
    logic signed [MUL_AW+1:0] r_hi;
    logic        [MUL_BW-1:0] r_lo;
    logic        [MUL_CW-1:0] r_cnt;
    logic                     r_busy;

    logic                     last;
    logic signed [MUL_AW+1:0] addend;
    logic signed [MUL_AW+1:0] sum;
    logic signed [MUL_AW+1:0] n_hi;
    logic        [MUL_BW-1:0] n_lo;

    always_comb begin
        last   = (r_cnt == MUL_CW'(MUL_BW - 1));
        addend = '0;
        if (r_lo[0]) begin
            addend = last ? -(MUL_AW+2)'(r_a) : (MUL_AW+2)'(r_a);
        end
        sum  = r_hi + addend;
        n_hi = sum >>> 1;
        n_lo = {sum[0], r_lo[MUL_BW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_a    <= i_a;
            r_hi   <= '0;
            r_lo   <= i_b;
        end else if (r_busy) begin
            r_hi  <= n_hi;
            r_lo  <= n_lo;
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_hi[MUL_AW-1:0], r_lo};

endmodule

// ----- hw/rtl/odr_cordic.sv -----
// ----------------------------------------------------------------------------
// odr_cordic: iterative rotation-mode CORDIC
// Folds the angle into the right half plane, then one rotation per cycle.
// ----------------------------------------------------------------------------
module odr_cordic import odr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_angle,
    output logic                 o_busy,
    output logic signed [CW-1:0] o_cos,
    output logic signed [CW-1:0] o_sin
);

    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic signed [CW-1:0]    r_z;
    logic                    r_neg;
    logic [CORDIC_IW-1:0]    r_i;
    logic                    r_busy;

    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] zf;
    logic                 negf;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;

    always_comb begin
        z0   = {i_angle[31], i_angle};
        zf   = z0;
        negf = 1'b0;
        if (z0 > QUARTER_TURN) begin
            zf   = z0 - HALF_TURN;
            negf = 1'b1;
        end else if (z0 < -QUARTER_TURN) begin
            zf   = z0 + HALF_TURN;
            negf = 1'b1;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = atan_val(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_x    <= INV_GAIN_Q30;
            r_y    <= '0;
            r_z    <= zf;
            r_neg  <= negf;
        end else if (r_busy) begin
            if (!r_z[CW-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_i <= r_i + 1'b1;
            if (r_i == CORDIC_IW'(CORDIC_ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ----- hw/rtl/odometry_dead_reckoning_unit.sv -----
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_unit: encoder plus compass pose tracker
// Midpoint-heading dead reckoning with CORDIC and a bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one encoder count, yaw and
//   timestamp per transfer. Output channel (o_out_valid / i_out_stall) returns
//   exactly one pose per input transfer, in order.
//   The first reading after reset only captures the count and yaw offset and
//   returns a pose with pose_valid = 0. For every later reading the
//   bit-serial multiplier runs three times (distance, x step, y step); the
//   16-step CORDIC runs alongside the first multiply. One reading is in work
//   at a time. The finished pose sits in an output register, so a new
//   reading is taken while the previous pose still waits for the receiver.
//   When the receiver stalls with the output register full, the block holds
//   the completed pose internally and keeps o_in_stall high until the
//   register frees up.
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) are taken
//   any cycle; write only while the block is idle.
//   Synchronous active-low reset clears the pose, the start flag and restores
//   the register defaults.
// ----------------------------------------------------------------------------
module odometry_dead_reckoning_unit import odr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_encoder_count,
    input  logic signed [15:0] i_yaw_angle,
    input  logic [31:0]        i_sample_time,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_pose_valid,
    output logic signed [47:0] o_pos_x,
    output logic signed [47:0] o_pos_y,
    output logic signed [15:0] o_heading,
    output logic [31:0]        o_pose_time,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_LAUNCH, S_WAIT_D, S_LAUNCH_X, S_WAIT_X,
        S_LAUNCH_Y, S_WAIT_Y, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [16:0] r_pulse_max;
    logic [15:0] r_wrap_threshold;
    logic [15:0] r_reverse_window;
    logic [31:0] r_dist_per_pulse;

    // tracking state
    logic               r_started;
    logic [15:0]        r_prev_count;
    logic [15:0]        r_yaw_offset;
    logic [15:0]        r_prev_heading;
    logic signed [47:0] r_acc_x;
    logic signed [47:0] r_acc_y;

    // per-reading work registers
    logic [15:0]        r_cnt;
    logic [15:0]        r_yaw;
    logic [31:0]        r_time;
    logic [15:0]        r_hdg;
    logic signed [18:0] r_d;
    logic signed [35:0] r_dist;
    logic signed [25:0] r_c24;
    logic signed [25:0] r_s24;
    logic               r_res_pv;

    // output register
    logic               r_out_valid;
    logic               r_o_pose_valid;
    logic signed [47:0] r_o_pos_x;
    logic signed [47:0] r_o_pos_y;
    logic [15:0]        r_o_heading;
    logic [31:0]        r_o_pose_time;

    // shared units
    logic                     mul_start;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic                     mul_busy;
    logic signed [MUL_PW-1:0] mul_prod;
    logic                     cor_start;
    logic [31:0]              cor_angle;
    logic                     cor_busy;
    logic signed [CW-1:0]     cor_cos;
    logic signed [CW-1:0]     cor_sin;

    logic               in_xfer;
    logic               out_load;
    logic signed [18:0] d0;
    logic signed [18:0] n_d;
    logic [15:0]        n_hdg;
    logic signed [17:0] ang_sum;
    logic signed [44:0] step;
    logic signed [47:0] acc_sel;
    logic signed [48:0] acc_sum;
    logic signed [47:0] n_acc;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // heading and count delta unwrap
    always_comb begin
        n_hdg = r_yaw - r_yaw_offset + HEADING_INIT;
        d0    = $signed({3'b000, r_cnt}) - $signed({3'b000, r_prev_count});
        n_d   = d0;
        if (d0 > $signed({3'b000, r_wrap_threshold})) begin
            n_d = d0 - $signed({2'b00, r_pulse_max});
        end else if (d0 < -$signed({3'b000, r_wrap_threshold})) begin
            n_d = d0 + $signed({2'b00, r_pulse_max});
        end else if (d0[18] && (d0 > -$signed({3'b000, r_reverse_window}))) begin
            // short backward move: travel forward on the flipped heading
            n_d   = -d0;
            n_hdg = n_hdg + 16'h8000;
        end
    end

    // midpoint angle: exact sum of both headings scaled to a 32-bit turn
    always_comb begin
        ang_sum   = 18'(angle_val(r_hdg)) + 18'(angle_val(r_prev_heading));
        cor_angle = {ang_sum[16:0], 15'b0};
    end

    // unit launches and saturating accumulate
    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_dist;
        mul_b     = MUL_BW'(r_c24);
        cor_start = 1'b0;
        unique case (r_state)
            S_LAUNCH: begin
                mul_start = 1'b1;
                cor_start = 1'b1;
                mul_a     = MUL_AW'(r_d);
                mul_b     = {1'b0, r_dist_per_pulse};
            end
            S_LAUNCH_X: begin
                mul_start = 1'b1;
                mul_b     = MUL_BW'(r_c24);
            end
            S_LAUNCH_Y: begin
                mul_start = 1'b1;
                mul_b     = MUL_BW'(r_s24);
            end
            default: begin
            end
        endcase

        step    = mul_prod[68:24];
        acc_sel = (r_state == S_WAIT_Y) ? r_acc_y : r_acc_x;
        acc_sum = 49'(acc_sel) + 49'(step);
        n_acc   = acc_sum[47:0];
        if (acc_sum[48] != acc_sum[47]) begin
            n_acc = acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_pulse_max      <= 17'd65536;
            r_wrap_threshold <= 16'd29000;
            r_reverse_window <= 16'd1000;
            r_dist_per_pulse <= 32'd65536;
            r_started        <= 1'b0;
            r_prev_count     <= '0;
            r_yaw_offset     <= '0;
            r_prev_heading   <= '0;
            r_acc_x          <= '0;
            r_acc_y          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PULSE_MAX:      r_pulse_max      <= i_cfg_data[16:0];
                    CFG_WRAP_THRESHOLD: r_wrap_threshold <= i_cfg_data[15:0];
                    CFG_REVERSE_WINDOW: r_reverse_window <= i_cfg_data[15:0];
                    CFG_DIST_PER_PULSE: r_dist_per_pulse <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cnt  <= i_encoder_count;
                        r_yaw  <= i_yaw_angle;
                        r_time <= i_sample_time;
                        if (!r_started) begin
                            // first reading: capture reference, no motion
                            r_prev_count   <= i_encoder_count;
                            r_yaw_offset   <= i_yaw_angle;
                            r_prev_heading <= HEADING_INIT;
                            r_started      <= 1'b1;
                            r_hdg          <= HEADING_INIT;
                            r_res_pv       <= 1'b0;
                            r_state        <= S_DONE;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_hdg    <= n_hdg;
                    r_d      <= n_d;
                    r_res_pv <= 1'b1;
                    r_state  <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_state <= S_WAIT_D;
                end
                S_WAIT_D: begin
                    if (!mul_busy && !cor_busy) begin
                        r_dist  <= mul_prod[51:16];
                        r_c24   <= cor_cos[31:6];
                        r_s24   <= cor_sin[31:6];
                        r_state <= S_LAUNCH_X;
                    end
                end
                S_LAUNCH_X: begin
                    r_state <= S_WAIT_X;
                end
                S_WAIT_X: begin
                    if (!mul_busy) begin
                        r_acc_x <= n_acc;
                        r_state <= S_LAUNCH_Y;
                    end
                end
                S_LAUNCH_Y: begin
                    r_state <= S_WAIT_Y;
                end
                S_WAIT_Y: begin
                    if (!mul_busy) begin
                        r_acc_y        <= n_acc;
                        r_prev_heading <= r_hdg;
                        r_prev_count   <= r_cnt;
                        r_state        <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_pose_valid <= r_res_pv;
            r_o_pos_x      <= r_acc_x;
            r_o_pos_y      <= r_acc_y;
            r_o_heading    <= r_hdg;
            r_o_pose_time  <= r_time;
        end
    end

    odr_serial_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    odr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_busy  (cor_busy),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_pose_valid = r_o_pose_valid;
    assign o_pos_x      = r_o_pos_x;
    assign o_pos_y      = r_o_pos_y;
    assign o_heading    = r_o_heading;
    assign o_pose_time  = r_o_pose_time;

    // launch a unit only when it is free
    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier launched while busy");

    a_cor_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_start |-> !cor_busy)
        else $error("cordic launched while busy");

    // a reading taken before the block has started yields an initializing pose
    a_init_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_started) |=> (r_state == S_DONE) && !r_res_pv)
        else $error("first reading not handled as initialization");

    // a transfer on the input never happens while a reading is in work
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken while a reading is in work");

endmodule
